[rtl/core/cpu8_pkg.sv]
// Shared types, constants and helpers for the 8-bit execute unit.
package cpu8_pkg;

	// Stream widths: input is func then operand; output result padded to whole bytes
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 56;
	localparam int RES_W    = 54;

	localparam logic [7:0] SP_RESET  = 8'hFD;
	localparam logic [7:0] ST_UNUSED = 8'h20;
	localparam logic [7:0] ST_BREAK  = 8'h10;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ORA,
		OP_AND,
		OP_EOR,
		OP_ADC,
		OP_SBC,
		OP_CMP,
		OP_BIT,
		OP_MOV,
		OP_SHIFT,
		OP_INC,
		OP_DEC,
		OP_PUSH,
		OP_PULL,
		OP_FLAG,
		OP_BRANCH,
		OP_CTRL,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		REG_NONE,
		REG_A,
		REG_X,
		REG_Y,
		REG_S,
		REG_M,
		REG_P
	} reg_t;

	typedef enum logic [1:0] {
		SH_ASL,
		SH_LSR,
		SH_ROL,
		SH_ROR
	} shift_t;

	typedef enum logic [2:0] {
		FL_C,
		FL_Z,
		FL_I,
		FL_D,
		FL_V,
		FL_N
	} flag_t;

	typedef enum logic [1:0] {
		OC_DONE = 2'd0,
		OC_CTRL = 2'd1,
		OC_BAD  = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		SA_NONE = 2'd0,
		SA_PUSH = 2'd1,
		SA_PULL = 2'd2
	} stack_t;

	typedef struct packed {
		op_t    op;
		reg_t   src;
		reg_t   dst;
		shift_t shift;
		flag_t  flag;
		logic   fval;
	} decode_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] s;
		logic       c;
		logic       z;
		logic       i;
		logic       d;
		logic       v;
		logic       n;
	} cpu_state_t;

	// Listed highest bits first so that the packed form matches the output beat
	typedef struct packed {
		outcome_t   outcome;
		logic [7:0] index_y_out;
		logic [7:0] index_x_out;
		logic [7:0] acc_out;
		logic [7:0] status_byte;
		logic       branch_taken;
		logic [7:0] stack_index;
		stack_t     stack_access;
		logic       write_enable;
		logic [7:0] write_data;
	} result_t;

	// Pack flags as N V 1 B D I Z C with B clear
	function automatic logic [7:0] pack_status(input cpu_state_t st);
		pack_status = {st.n, st.v, 1'b0, 1'b0, st.d, st.i, st.z, st.c} | ST_UNUSED;
	endfunction

endpackage

[rtl/core/cpu8_decode.sv]
// Opcode decoder: maps an opcode byte to operation class and operand routing.
module cpu8_decode (
	input  logic [7:0]       func,
	output cpu8_pkg::decode_t dec
);
	import cpu8_pkg::*;

	// Classify the opcode
	always_comb begin
		dec.op    = OP_BAD;
		dec.src   = REG_NONE;
		dec.dst   = REG_NONE;
		dec.shift = SH_ASL;
		dec.flag  = FL_C;
		dec.fval  = 1'b0;
		unique case (func) inside
			8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: dec.op = OP_ORA;
			8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: dec.op = OP_AND;
			8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: dec.op = OP_EOR;
			8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: dec.op = OP_ADC;
			8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: dec.op = OP_SBC;
			8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: begin
				dec.op = OP_CMP; dec.src = REG_A;
			end
			8'hE0, 8'hE4, 8'hEC: begin
				dec.op = OP_CMP; dec.src = REG_X;
			end
			8'hC0, 8'hC4, 8'hCC: begin
				dec.op = OP_CMP; dec.src = REG_Y;
			end
			8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: begin
				dec.op = OP_MOV; dec.src = REG_M; dec.dst = REG_A;
			end
			8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin
				dec.op = OP_MOV; dec.src = REG_M; dec.dst = REG_X;
			end
			8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin
				dec.op = OP_MOV; dec.src = REG_M; dec.dst = REG_Y;
			end
			8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: begin
				dec.op = OP_MOV; dec.src = REG_A; dec.dst = REG_M;
			end
			8'h86, 8'h96, 8'h8E: begin
				dec.op = OP_MOV; dec.src = REG_X; dec.dst = REG_M;
			end
			8'h84, 8'h94, 8'h8C: begin
				dec.op = OP_MOV; dec.src = REG_Y; dec.dst = REG_M;
			end
			8'h24, 8'h2C: dec.op = OP_BIT;
			8'h0A: begin
				dec.op = OP_SHIFT; dec.src = REG_A; dec.dst = REG_A; dec.shift = SH_ASL;
			end
			8'h4A: begin
				dec.op = OP_SHIFT; dec.src = REG_A; dec.dst = REG_A; dec.shift = SH_LSR;
			end
			8'h2A: begin
				dec.op = OP_SHIFT; dec.src = REG_A; dec.dst = REG_A; dec.shift = SH_ROL;
			end
			8'h6A: begin
				dec.op = OP_SHIFT; dec.src = REG_A; dec.dst = REG_A; dec.shift = SH_ROR;
			end
			8'h06, 8'h16, 8'h0E, 8'h1E: begin
				dec.op = OP_SHIFT; dec.src = REG_M; dec.dst = REG_M; dec.shift = SH_ASL;
			end
			8'h46, 8'h56, 8'h4E, 8'h5E: begin
				dec.op = OP_SHIFT; dec.src = REG_M; dec.dst = REG_M; dec.shift = SH_LSR;
			end
			8'h26, 8'h36, 8'h2E, 8'h3E: begin
				dec.op = OP_SHIFT; dec.src = REG_M; dec.dst = REG_M; dec.shift = SH_ROL;
			end
			8'h66, 8'h76, 8'h6E, 8'h7E: begin
				dec.op = OP_SHIFT; dec.src = REG_M; dec.dst = REG_M; dec.shift = SH_ROR;
			end
			8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
				dec.op = OP_INC; dec.src = REG_M; dec.dst = REG_M;
			end
			8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
				dec.op = OP_DEC; dec.src = REG_M; dec.dst = REG_M;
			end
			8'hE8: begin
				dec.op = OP_INC; dec.src = REG_X; dec.dst = REG_X;
			end
			8'hC8: begin
				dec.op = OP_INC; dec.src = REG_Y; dec.dst = REG_Y;
			end
			8'hCA: begin
				dec.op = OP_DEC; dec.src = REG_X; dec.dst = REG_X;
			end
			8'h88: begin
				dec.op = OP_DEC; dec.src = REG_Y; dec.dst = REG_Y;
			end
			8'hAA: begin
				dec.op = OP_MOV; dec.src = REG_A; dec.dst = REG_X;
			end
			8'hA8: begin
				dec.op = OP_MOV; dec.src = REG_A; dec.dst = REG_Y;
			end
			8'h8A: begin
				dec.op = OP_MOV; dec.src = REG_X; dec.dst = REG_A;
			end
			8'h98: begin
				dec.op = OP_MOV; dec.src = REG_Y; dec.dst = REG_A;
			end
			8'hBA: begin
				dec.op = OP_MOV; dec.src = REG_S; dec.dst = REG_X;
			end
			8'h9A: begin
				dec.op = OP_MOV; dec.src = REG_X; dec.dst = REG_S;
			end
			8'h48: begin
				dec.op = OP_PUSH; dec.src = REG_A;
			end
			8'h08: begin
				dec.op = OP_PUSH; dec.src = REG_P;
			end
			8'h68: begin
				dec.op = OP_PULL; dec.dst = REG_A;
			end
			8'h28: begin
				dec.op = OP_PULL; dec.dst = REG_P;
			end
			8'h18: begin
				dec.op = OP_FLAG; dec.flag = FL_C; dec.fval = 1'b0;
			end
			8'h38: begin
				dec.op = OP_FLAG; dec.flag = FL_C; dec.fval = 1'b1;
			end
			8'h58: begin
				dec.op = OP_FLAG; dec.flag = FL_I; dec.fval = 1'b0;
			end
			8'h78: begin
				dec.op = OP_FLAG; dec.flag = FL_I; dec.fval = 1'b1;
			end
			8'hB8: begin
				dec.op = OP_FLAG; dec.flag = FL_V; dec.fval = 1'b0;
			end
			8'hD8: begin
				dec.op = OP_FLAG; dec.flag = FL_D; dec.fval = 1'b0;
			end
			8'hF8: begin
				dec.op = OP_FLAG; dec.flag = FL_D; dec.fval = 1'b1;
			end
			8'h10: begin
				dec.op = OP_BRANCH; dec.flag = FL_N; dec.fval = 1'b0;
			end
			8'h30: begin
				dec.op = OP_BRANCH; dec.flag = FL_N; dec.fval = 1'b1;
			end
			8'h50: begin
				dec.op = OP_BRANCH; dec.flag = FL_V; dec.fval = 1'b0;
			end
			8'h70: begin
				dec.op = OP_BRANCH; dec.flag = FL_V; dec.fval = 1'b1;
			end
			8'h90: begin
				dec.op = OP_BRANCH; dec.flag = FL_C; dec.fval = 1'b0;
			end
			8'hB0: begin
				dec.op = OP_BRANCH; dec.flag = FL_C; dec.fval = 1'b1;
			end
			8'hD0: begin
				dec.op = OP_BRANCH; dec.flag = FL_Z; dec.fval = 1'b0;
			end
			8'hF0: begin
				dec.op = OP_BRANCH; dec.flag = FL_Z; dec.fval = 1'b1;
			end
			8'hEA: dec.op = OP_NOP;
			8'h00, 8'h20, 8'h40, 8'h60, 8'h4C, 8'h6C: dec.op = OP_CTRL;
			default: dec.op = OP_BAD;
		endcase
	end

endmodule

[rtl/core/cpu8_exec.sv]
// Execute datapath: 8-bit ALU, shifter, stack and flag update for one instruction.
module cpu8_exec (
	input  cpu8_pkg::decode_t    dec,
	input  logic [7:0]           operand,
	input  cpu8_pkg::cpu_state_t cur,
	output cpu8_pkg::cpu_state_t nxt,
	output cpu8_pkg::result_t    res
);
	import cpu8_pkg::*;

	logic [7:0] src_val;
	logic       flag_val;
	logic [7:0] addend;
	logic [8:0] sum;
	logic [8:0] diff;

	// Pick the source byte
	always_comb begin
		case (dec.src)
			REG_A:   src_val = cur.a;
			REG_X:   src_val = cur.x;
			REG_Y:   src_val = cur.y;
			REG_S:   src_val = cur.s;
			REG_M:   src_val = operand;
			REG_P:   src_val = pack_status(cur) | ST_BREAK;
			default: src_val = 8'h00;
		endcase
	end

	// Pick the flag tested by a branch
	always_comb begin
		case (dec.flag)
			FL_C:    flag_val = cur.c;
			FL_Z:    flag_val = cur.z;
			FL_I:    flag_val = cur.i;
			FL_D:    flag_val = cur.d;
			FL_V:    flag_val = cur.v;
			FL_N:    flag_val = cur.n;
			default: flag_val = 1'b0;
		endcase
	end

	// Binary adder for ADC and SBC, subtractor for compares
	assign addend = (dec.op == OP_SBC) ? ~operand : operand;
	assign sum    = {1'b0, cur.a} + {1'b0, addend} + {8'h00, cur.c};
	assign diff   = {1'b0, src_val} - {1'b0, operand};

	// Operate, then write back the result byte
	always_comb begin
		logic [7:0] r;
		reg_t       dst_w;
		logic       set_nz;
		nxt    = cur;
		res    = '0;
		r      = 8'h00;
		dst_w  = REG_NONE;
		set_nz = 1'b0;
		res.outcome      = OC_DONE;
		res.stack_access = SA_NONE;
		case (dec.op)
			OP_ORA: begin
				r = cur.a | operand; dst_w = REG_A; set_nz = 1'b1;
			end
			OP_AND: begin
				r = cur.a & operand; dst_w = REG_A; set_nz = 1'b1;
			end
			OP_EOR: begin
				r = cur.a ^ operand; dst_w = REG_A; set_nz = 1'b1;
			end
			OP_ADC, OP_SBC: begin
				r      = sum[7:0];
				nxt.c  = sum[8];
				nxt.v  = (cur.a[7] ^ sum[7]) & (addend[7] ^ sum[7]);
				dst_w  = REG_A;
				set_nz = 1'b1;
			end
			OP_CMP: begin
				r = diff[7:0]; nxt.c = ~diff[8]; set_nz = 1'b1;
			end
			OP_BIT: begin
				nxt.z = ((cur.a & operand) == 8'h00);
				nxt.v = operand[6];
				nxt.n = operand[7];
			end
			OP_MOV: begin
				r      = src_val;
				dst_w  = dec.dst;
				set_nz = (dec.dst != REG_M) && (dec.dst != REG_S);
			end
			OP_SHIFT: begin
				case (dec.shift)
					SH_ASL: begin
						r = {src_val[6:0], 1'b0}; nxt.c = src_val[7];
					end
					SH_LSR: begin
						r = {1'b0, src_val[7:1]}; nxt.c = src_val[0];
					end
					SH_ROL: begin
						r = {src_val[6:0], cur.c}; nxt.c = src_val[7];
					end
					default: begin
						r = {cur.c, src_val[7:1]}; nxt.c = src_val[0];
					end
				endcase
				dst_w  = dec.dst;
				set_nz = 1'b1;
			end
			OP_INC: begin
				r = src_val + 8'd1; dst_w = dec.dst; set_nz = 1'b1;
			end
			OP_DEC: begin
				r = src_val - 8'd1; dst_w = dec.dst; set_nz = 1'b1;
			end
			OP_PUSH: begin
				r                = src_val;
				dst_w            = REG_M;
				res.stack_access = SA_PUSH;
				res.stack_index  = cur.s;
				nxt.s            = cur.s - 8'd1;
			end
			OP_PULL: begin
				nxt.s            = cur.s + 8'd1;
				res.stack_access = SA_PULL;
				res.stack_index  = cur.s + 8'd1;
				if (dec.dst == REG_A) begin
					r = operand; dst_w = REG_A; set_nz = 1'b1;
				end else begin
					nxt.n = operand[7];
					nxt.v = operand[6];
					nxt.d = operand[3];
					nxt.i = operand[2];
					nxt.z = operand[1];
					nxt.c = operand[0];
				end
			end
			OP_FLAG: begin
				case (dec.flag)
					FL_C:    nxt.c = dec.fval;
					FL_I:    nxt.i = dec.fval;
					FL_D:    nxt.d = dec.fval;
					FL_V:    nxt.v = dec.fval;
					default: nxt.c = cur.c;
				endcase
			end
			OP_BRANCH: res.branch_taken = (flag_val == dec.fval);
			OP_CTRL:   res.outcome = OC_CTRL;
			OP_BAD:    res.outcome = OC_BAD;
			default:   r = 8'h00;
		endcase

		// Write back to a register or to memory
		case (dst_w)
			REG_A: nxt.a = r;
			REG_X: nxt.x = r;
			REG_Y: nxt.y = r;
			REG_S: nxt.s = r;
			REG_M: begin
				res.write_data   = r;
				res.write_enable = 1'b1;
			end
			default: r = r;
		endcase
		if (set_nz) begin
			nxt.z = (r == 8'h00);
			nxt.n = r[7];
		end

		res.status_byte = pack_status(nxt);
		res.acc_out     = nxt.a;
		res.index_x_out = nxt.x;
		res.index_y_out = nxt.y;
	end

endmodule

[rtl/core/eight_bit_cpu_execute_unit.sv]
// An accepted input beat passes the input register and then the result register.
// Throughput: one instruction per cycle unless the output stalls; decode and the
// 8-bit ALU sit between the input register and the result register, and the
// register file updates as the instruction leaves the input register, so the
// next one sees it at once. Reset (arst_n low, asynchronous): A, X, Y and flags
// clear, I set, stack pointer 0xFD, both stages empty.
module eight_bit_cpu_execute_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] func, [15:8] operand
	input  logic [cpu8_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] write_data, [8] write_enable, [10:9] stack_access, [18:11] stack_index,
	// [19] branch_taken, [27:20] status_byte, [35:28] acc_out, [43:36] index_x_out,
	// [51:44] index_y_out, [53:52] outcome, [55:54] zero
	output logic [cpu8_pkg::M_DATA_W-1:0] m_tdata
);
	import cpu8_pkg::*;

	logic       valid_s1;
	logic [7:0] func_s1;
	logic [7:0] operand_s1;
	logic       advance;
	cpu_state_t st_q;
	cpu_state_t st_nxt;
	decode_t    dec;
	result_t    res;
	result_t    res_q;
	logic       m_valid_q;

	// Move the instruction on when the result register is free or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1    <= s_tdata[7:0];
			operand_s1 <= s_tdata[15:8];
		end
	end

	cpu8_decode u_decode (
		.func (func_s1),
		.dec  (dec)
	);

	cpu8_exec u_exec (
		.dec     (dec),
		.operand (operand_s1),
		.cur     (st_q),
		.nxt     (st_nxt),
		.res     (res)
	);

	// Register file and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: SP_RESET,
				c: 1'b0, z: 1'b0, i: 1'b1, d: 1'b0, v: 1'b0, n: 1'b0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, res_q};

endmodule

[rtl/core/cpu8_checker.sv]
// Port-level checks for the execute unit, bound to the top level.
module cpu8_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cpu8_pkg::M_DATA_W-1:0] m_tdata
);
	import cpu8_pkg::*;

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Status byte always shows bit 5 set and B clear
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25] && !m_tdata[24])
		else $error("status byte fixed bits wrong");

	// Control-flow and unsupported opcodes have no side effects
	a_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[53:52] != OC_DONE) |->
			!m_tdata[8] && (m_tdata[10:9] == SA_NONE) && !m_tdata[19])
		else $error("side effect on a non-executed opcode");

	// A push always writes; a pull never does
	a_stack_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:9] != SA_NONE) |->
			((m_tdata[10:9] == SA_PUSH) || (m_tdata[10:9] == SA_PULL)) &&
			(m_tdata[8] == (m_tdata[10:9] == SA_PUSH)))
		else $error("stack access and write enable disagree");

	// No stack index without a stack access
	a_stack_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:9] == SA_NONE) |-> m_tdata[18:11] == 8'h00)
		else $error("stack index set without stack access");

endmodule

bind eight_bit_cpu_execute_unit cpu8_checker u_cpu8_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/cpu8_opcode_pkg.sv]
// Opcode table and named opcodes shared by the execute unit checker and stimulus.
package cpu8_opcode_pkg;

	// Instruction families as the execute unit sees them
	typedef enum logic [5:0] {
		MN_ORA, MN_AND, MN_EOR, MN_ADC, MN_SBC, MN_CMP, MN_CPX, MN_CPY,
		MN_LDA, MN_LDX, MN_LDY, MN_STA, MN_STX, MN_STY, MN_BIT,
		MN_ASL_A, MN_LSR_A, MN_ROL_A, MN_ROR_A,
		MN_ASL_M, MN_LSR_M, MN_ROL_M, MN_ROR_M, MN_INC, MN_DEC,
		MN_INX, MN_INY, MN_DEX, MN_DEY,
		MN_TAX, MN_TAY, MN_TXA, MN_TYA, MN_TSX, MN_TXS,
		MN_PHA, MN_PHP, MN_PLA, MN_PLP,
		MN_CLC, MN_SEC, MN_CLI, MN_SEI, MN_CLV, MN_CLD, MN_SED,
		MN_BPL, MN_BMI, MN_BVC, MN_BVS, MN_BCC, MN_BCS, MN_BNE, MN_BEQ,
		MN_NOP, MN_CTRL, MN_ILL
	} mnem_t;

	// Opcodes driven by name in the directed part
	localparam logic [7:0] OPC_NOP     = 8'hEA;
	localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
	localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
	localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
	localparam logic [7:0] OPC_ADC_IMM = 8'h69;
	localparam logic [7:0] OPC_SBC_IMM = 8'hE9;
	localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
	localparam logic [7:0] OPC_CPX_IMM = 8'hE0;
	localparam logic [7:0] OPC_INX     = 8'hE8;
	localparam logic [7:0] OPC_DEY     = 8'h88;
	localparam logic [7:0] OPC_TXS     = 8'h9A;
	localparam logic [7:0] OPC_TSX     = 8'hBA;
	localparam logic [7:0] OPC_PHA     = 8'h48;
	localparam logic [7:0] OPC_PHP     = 8'h08;
	localparam logic [7:0] OPC_PLA     = 8'h68;
	localparam logic [7:0] OPC_PLP     = 8'h28;
	localparam logic [7:0] OPC_SED     = 8'hF8;
	localparam logic [7:0] OPC_BEQ     = 8'hF0;
	localparam logic [7:0] OPC_BCC     = 8'h90;
	localparam logic [7:0] OPC_ASL_A   = 8'h0A;
	localparam logic [7:0] OPC_ROR_ZP  = 8'h66;
	localparam logic [7:0] OPC_INC_ZP  = 8'hE6;
	localparam logic [7:0] OPC_DEC_ZP  = 8'hC6;
	localparam logic [7:0] OPC_BIT_ABS = 8'h2C;
	localparam logic [7:0] OPC_STA_ZP  = 8'h85;
	localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
	localparam logic [7:0] OPC_UNDOC   = 8'h02;

	// Map an opcode byte onto its instruction family
	function automatic mnem_t decode_mnemonic(input logic [7:0] op);
		case (op)
			8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: return MN_ORA;
			8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: return MN_AND;
			8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: return MN_EOR;
			8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: return MN_ADC;
			8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: return MN_SBC;
			8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: return MN_CMP;
			8'hE0, 8'hE4, 8'hEC: return MN_CPX;
			8'hC0, 8'hC4, 8'hCC: return MN_CPY;
			8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: return MN_LDA;
			8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: return MN_LDX;
			8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: return MN_LDY;
			8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: return MN_STA;
			8'h86, 8'h96, 8'h8E: return MN_STX;
			8'h84, 8'h94, 8'h8C: return MN_STY;
			8'h24, 8'h2C: return MN_BIT;
			8'h0A: return MN_ASL_A;
			8'h4A: return MN_LSR_A;
			8'h2A: return MN_ROL_A;
			8'h6A: return MN_ROR_A;
			8'h06, 8'h16, 8'h0E, 8'h1E: return MN_ASL_M;
			8'h46, 8'h56, 8'h4E, 8'h5E: return MN_LSR_M;
			8'h26, 8'h36, 8'h2E, 8'h3E: return MN_ROL_M;
			8'h66, 8'h76, 8'h6E, 8'h7E: return MN_ROR_M;
			8'hE6, 8'hF6, 8'hEE, 8'hFE: return MN_INC;
			8'hC6, 8'hD6, 8'hCE, 8'hDE: return MN_DEC;
			8'hE8: return MN_INX;
			8'hC8: return MN_INY;
			8'hCA: return MN_DEX;
			8'h88: return MN_DEY;
			8'hAA: return MN_TAX;
			8'hA8: return MN_TAY;
			8'h8A: return MN_TXA;
			8'h98: return MN_TYA;
			8'hBA: return MN_TSX;
			8'h9A: return MN_TXS;
			8'h48: return MN_PHA;
			8'h08: return MN_PHP;
			8'h68: return MN_PLA;
			8'h28: return MN_PLP;
			8'h18: return MN_CLC;
			8'h38: return MN_SEC;
			8'h58: return MN_CLI;
			8'h78: return MN_SEI;
			8'hB8: return MN_CLV;
			8'hD8: return MN_CLD;
			8'hF8: return MN_SED;
			8'h10: return MN_BPL;
			8'h30: return MN_BMI;
			8'h50: return MN_BVC;
			8'h70: return MN_BVS;
			8'h90: return MN_BCC;
			8'hB0: return MN_BCS;
			8'hD0: return MN_BNE;
			8'hF0: return MN_BEQ;
			8'hEA: return MN_NOP;
			8'h00, 8'h20, 8'h40, 8'h60, 8'h4C, 8'h6C: return MN_CTRL;
			default: return MN_ILL;
		endcase
	endfunction

endpackage

[verif/exec_unit_checker.sv]
// Scoreboard for the execute unit: predicts every result beat and compares it field by field.
module exec_unit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [cpu8_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [cpu8_pkg::M_DATA_W-1:0] m_tdata,
	output int                            fail_count,
	output int                            pending
);
	import cpu8_pkg::*;
	import cpu8_opcode_pkg::*;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic       c;
		logic       z;
		logic       i;
		logic       d;
		logic       v;
		logic       n;
	} arch_t;

	arch_t   arch;
	result_t predicted_beats[$];
	int      errors = 0;
	int      outstanding = 0;
	int      beats_seen = 0;

	assign fail_count = errors;
	assign pending    = outstanding;

	function automatic logic [7:0] status_of(input arch_t s);
		return {s.n, s.v, 2'b00, s.d, s.i, s.z, s.c} | ST_UNUSED;
	endfunction

	function automatic void set_nz(inout arch_t s, input logic [7:0] val);
		s.z = (val == 8'h00);
		s.n = val[7];
	endfunction

	// Binary add with carry; SBC comes in with the operand inverted
	function automatic void add_with_carry(inout arch_t s, input logic [7:0] val);
		logic [8:0] sum;
		logic [7:0] r;
		sum = {1'b0, s.a} + {1'b0, val} + {8'h00, s.c};
		r = sum[7:0];
		s.v = (s.a[7] ^ r[7]) & (val[7] ^ r[7]);
		s.c = sum[8];
		s.a = r;
		set_nz(s, r);
	endfunction

	function automatic void compare_with(inout arch_t s, input logic [7:0] lhs,
			input logic [7:0] rhs);
		logic [7:0] diff;
		diff = lhs - rhs;
		s.c = (lhs >= rhs);
		set_nz(s, diff);
	endfunction

	// Work out the state after one instruction and the result beat it gives
	function automatic void execute_instr(input arch_t cur, input logic [7:0] op,
			input logic [7:0] d, output arch_t nxt, output result_t r);
		arch_t      s;
		logic [7:0] wd;
		logic       we;
		s  = cur;
		wd = 8'h00;
		we = 1'b0;
		r  = '0;
		r.stack_access = SA_NONE;
		r.outcome      = OC_DONE;
		case (decode_mnemonic(op))
			MN_ORA: begin s.a = s.a | d; set_nz(s, s.a); end
			MN_AND: begin s.a = s.a & d; set_nz(s, s.a); end
			MN_EOR: begin s.a = s.a ^ d; set_nz(s, s.a); end
			MN_ADC: add_with_carry(s, d);
			MN_SBC: add_with_carry(s, ~d);
			MN_CMP: compare_with(s, s.a, d);
			MN_CPX: compare_with(s, s.x, d);
			MN_CPY: compare_with(s, s.y, d);
			MN_LDA: begin s.a = d; set_nz(s, d); end
			MN_LDX: begin s.x = d; set_nz(s, d); end
			MN_LDY: begin s.y = d; set_nz(s, d); end
			MN_STA: begin wd = s.a; we = 1'b1; end
			MN_STX: begin wd = s.x; we = 1'b1; end
			MN_STY: begin wd = s.y; we = 1'b1; end
			MN_BIT: begin
				s.z = ((s.a & d) == 8'h00);
				s.v = d[6];
				s.n = d[7];
			end
			MN_ASL_A: begin s.c = s.a[7]; s.a = {s.a[6:0], 1'b0}; set_nz(s, s.a); end
			MN_LSR_A: begin s.c = s.a[0]; s.a = {1'b0, s.a[7:1]}; set_nz(s, s.a); end
			MN_ROL_A: begin
				s.a = {s.a[6:0], s.c};
				s.c = cur.a[7];
				set_nz(s, s.a);
			end
			MN_ROR_A: begin
				s.a = {s.c, s.a[7:1]};
				s.c = cur.a[0];
				set_nz(s, s.a);
			end
			// Memory forms write the shifted byte back
			MN_ASL_M: begin wd = {d[6:0], 1'b0}; s.c = d[7]; we = 1'b1; set_nz(s, wd); end
			MN_LSR_M: begin wd = {1'b0, d[7:1]}; s.c = d[0]; we = 1'b1; set_nz(s, wd); end
			MN_ROL_M: begin wd = {d[6:0], s.c}; s.c = d[7]; we = 1'b1; set_nz(s, wd); end
			MN_ROR_M: begin wd = {s.c, d[7:1]}; s.c = d[0]; we = 1'b1; set_nz(s, wd); end
			MN_INC: begin wd = d + 8'h01; we = 1'b1; set_nz(s, wd); end
			MN_DEC: begin wd = d - 8'h01; we = 1'b1; set_nz(s, wd); end
			MN_INX: begin s.x = s.x + 8'h01; set_nz(s, s.x); end
			MN_INY: begin s.y = s.y + 8'h01; set_nz(s, s.y); end
			MN_DEX: begin s.x = s.x - 8'h01; set_nz(s, s.x); end
			MN_DEY: begin s.y = s.y - 8'h01; set_nz(s, s.y); end
			MN_TAX: begin s.x = s.a; set_nz(s, s.a); end
			MN_TAY: begin s.y = s.a; set_nz(s, s.a); end
			MN_TXA: begin s.a = s.x; set_nz(s, s.x); end
			MN_TYA: begin s.a = s.y; set_nz(s, s.y); end
			MN_TSX: begin s.x = s.sp; set_nz(s, s.sp); end
			MN_TXS: s.sp = s.x;
			// Push writes at the current pointer, then decrements
			MN_PHA, MN_PHP: begin
				wd = (op == OPC_PHA) ? s.a : (status_of(s) | ST_BREAK);
				we = 1'b1;
				r.stack_access = SA_PUSH;
				r.stack_index  = s.sp;
				s.sp = s.sp - 8'h01;
			end
			// Pull increments first and reads at the new pointer
			MN_PLA, MN_PLP: begin
				s.sp = s.sp + 8'h01;
				r.stack_access = SA_PULL;
				r.stack_index  = s.sp;
				if (op == OPC_PLA) begin
					s.a = d;
					set_nz(s, d);
				end else begin
					s.n = d[7];
					s.v = d[6];
					s.d = d[3];
					s.i = d[2];
					s.z = d[1];
					s.c = d[0];
				end
			end
			MN_CLC: s.c = 1'b0;
			MN_SEC: s.c = 1'b1;
			MN_CLI: s.i = 1'b0;
			MN_SEI: s.i = 1'b1;
			MN_CLV: s.v = 1'b0;
			MN_CLD: s.d = 1'b0;
			MN_SED: s.d = 1'b1;
			MN_BPL: r.branch_taken = ~s.n;
			MN_BMI: r.branch_taken = s.n;
			MN_BVC: r.branch_taken = ~s.v;
			MN_BVS: r.branch_taken = s.v;
			MN_BCC: r.branch_taken = ~s.c;
			MN_BCS: r.branch_taken = s.c;
			MN_BNE: r.branch_taken = ~s.z;
			MN_BEQ: r.branch_taken = s.z;
			MN_NOP: ;
			MN_CTRL: r.outcome = OC_CTRL;
			default: r.outcome = OC_BAD;
		endcase
		r.write_data   = wd;
		r.write_enable = we;
		r.status_byte  = status_of(s);
		r.acc_out      = s.a;
		r.index_x_out  = s.x;
		r.index_y_out  = s.y;
		nxt = s;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("checker: beat %0d %s: got %02h, expected %02h", beats_seen, what, got,
			want);
		errors++;
	endtask

	// Compare output beats against the oldest prediction, then predict from input beats
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		arch_t   after;
		if (!arst_n) begin
			arch    = '0;
			arch.sp = SP_RESET;
			arch.i  = 1'b1;
			predicted_beats.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RES_W-1:0]);
				if (predicted_beats.size() == 0) begin
					report_mismatch("result beat with nothing predicted", got.acc_out, 8'h00);
				end else begin
					want = predicted_beats.pop_front();
					if (got.write_data !== want.write_data)
						report_mismatch("write_data", got.write_data, want.write_data);
					if (got.write_enable !== want.write_enable)
						report_mismatch("write_enable", 8'(got.write_enable),
							8'(want.write_enable));
					if (got.stack_access !== want.stack_access)
						report_mismatch("stack_access", 8'(got.stack_access),
							8'(want.stack_access));
					if (got.stack_index !== want.stack_index)
						report_mismatch("stack_index", got.stack_index, want.stack_index);
					if (got.branch_taken !== want.branch_taken)
						report_mismatch("branch_taken", 8'(got.branch_taken),
							8'(want.branch_taken));
					if (got.status_byte !== want.status_byte)
						report_mismatch("status_byte", got.status_byte, want.status_byte);
					if (got.acc_out !== want.acc_out)
						report_mismatch("acc_out", got.acc_out, want.acc_out);
					if (got.index_x_out !== want.index_x_out)
						report_mismatch("index_x_out", got.index_x_out, want.index_x_out);
					if (got.index_y_out !== want.index_y_out)
						report_mismatch("index_y_out", got.index_y_out, want.index_y_out);
					if (got.outcome !== want.outcome)
						report_mismatch("outcome", 8'(got.outcome), 8'(want.outcome));
				end
				beats_seen++;
			end
			if (s_tvalid && s_tready) begin
				execute_instr(arch, s_tdata[7:0], s_tdata[15:8], after, want);
				arch = after;
				predicted_beats.push_back(want);
			end
			outstanding = predicted_beats.size();
		end
	end

endmodule

[verif/tb_top.sv]
// Testbench top: drives instruction beats into the execute unit, throttles both sides, gives the verdict.
module tb_top;
	import cpu8_pkg::*;
	import cpu8_opcode_pkg::*;

	localparam int RANDOM_BEATS = 1200;
	localparam int CALM_BEATS   = 200;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                calm;
	int                  fail_count;
	int                  pending;

	eight_bit_cpu_execute_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	exec_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up well past the slowest legal run
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	// Mostly official opcodes, the rest any byte at all
	function automatic logic [7:0] pick_opcode();
		logic [7:0] op;
		op = 8'($urandom);
		if ($urandom_range(0, 6) != 0) begin
			while (decode_mnemonic(op) == MN_ILL) op = 8'($urandom);
		end
		return op;
	endfunction

	// Lean on the byte extremes now and then
	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	// Present one beat and hold it until the unit takes it
	task automatic send_beat(input logic [7:0] op, input logic [7:0] data);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {data, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid for a burst, with junk on the data lines
	task automatic hold_off(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tdata  <= S_DATA_W'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Throttle the result side in random bursts until the calm stretch
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 2) != 0) m_tready <= 1'b1;
			else m_tready <= 1'b0;
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
	end

	initial begin
		int n;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Reset state, then carry, overflow and zero corners of the adder
		send_beat(OPC_NOP, 8'h00);
		send_beat(OPC_LDA_IMM, 8'h80);
		send_beat(OPC_ADC_IMM, 8'h80);
		send_beat(OPC_ADC_IMM, 8'h7F);
		send_beat(OPC_SBC_IMM, 8'hFF);
		send_beat(OPC_CMP_IMM, 8'h80);
		// Index wrap both ways, compare against the top value
		send_beat(OPC_LDX_IMM, 8'hFF);
		send_beat(OPC_INX, 8'h00);
		send_beat(OPC_LDY_IMM, 8'h00);
		send_beat(OPC_DEY, 8'h00);
		send_beat(OPC_CPX_IMM, 8'hFF);
		// Stack pointer wraps on push from zero and on pull from the top
		send_beat(OPC_TXS, 8'h00);
		send_beat(OPC_PHA, 8'h00);
		send_beat(OPC_TSX, 8'h00);
		send_beat(OPC_PLA, 8'h00);
		// Pushed status carries the break bits; pulled status ignores them
		send_beat(OPC_SED, 8'h00);
		send_beat(OPC_PHP, 8'h00);
		send_beat(OPC_PLP, 8'hFF);
		send_beat(OPC_BEQ, 8'h00);
		send_beat(OPC_BCC, 8'h00);
		// Memory read-modify-write forms, BIT, store, control flow, undocumented
		send_beat(OPC_ROR_ZP, 8'h01);
		send_beat(OPC_ASL_A, 8'h00);
		send_beat(OPC_INC_ZP, 8'hFF);
		send_beat(OPC_DEC_ZP, 8'h00);
		send_beat(OPC_BIT_ABS, 8'hC0);
		send_beat(OPC_STA_ZP, 8'h00);
		send_beat(OPC_JMP_ABS, 8'h00);
		send_beat(OPC_UNDOC, 8'hFF);

		// Random instruction stream, full rate over the last stretch
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n == RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
			send_beat(pick_opcode(), pick_operand());
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain, then allow for the pipeline depth
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
